// File: hdl/sit_pkg.sv
// Shared types, constants and operation codes of the sorted interval table.
`timescale 1ns / 1ps
`default_nettype none
package sit_pkg;

  localparam int unsigned Capacity    = 64;
  localparam int unsigned PayloadBits = 16;
  localparam int unsigned AddrW       = $clog2(Capacity);
  localparam int unsigned CntW        = $clog2(Capacity + 1);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpQuery  = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;

  typedef struct packed {
    logic [31:0]            start;
    logic [31:0]            length;
    logic [PayloadBits-1:0] payload;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [1:0]             op;
    logic [31:0]            time_value;
    logic [31:0]            length_ticks;
    logic [PayloadBits-1:0] payload;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic                   table_full;
    logic [31:0]            found_start;
    logic [31:0]            found_length;
    logic [PayloadBits-1:0] found_payload;
    logic [CntW-1:0]        entry_count;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    entry_t            wdata;
    logic [AddrW-1:0]  raddr;
  } ram_req_t;

endpackage
`default_nettype wire

// File: hdl/sit_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface sit_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      op;
  logic [31:0]                     time_value;
  logic [31:0]                     length_ticks;
  logic [sit_pkg::PayloadBits-1:0] payload;

  modport source (output valid, op, time_value, length_ticks, payload, input ready);
  modport sink   (input valid, op, time_value, length_ticks, payload, output ready);
endinterface

interface sit_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic                            table_full;
  logic [31:0]                     found_start;
  logic [31:0]                     found_length;
  logic [sit_pkg::PayloadBits-1:0] found_payload;
  logic [sit_pkg::CntW-1:0]        entry_count;

  modport source (output valid, hit, table_full, found_start, found_length, found_payload,
                  entry_count, input ready);
  modport sink   (input valid, hit, table_full, found_start, found_length, found_payload,
                  entry_count, output ready);
endinterface
`default_nettype wire

// File: hdl/sit_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/sit_ctrl.sv
// Sequencer: scans the entry memory for each operation, and shifts and updates it for insert and remove.
`timescale 1ns / 1ps
`default_nettype none
module sit_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire sit_pkg::req_t     req_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output sit_pkg::res_t          res_o,
  output sit_pkg::ram_req_t      ram_o,
  input  wire sit_pkg::entry_t   ram_rdata_i
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StScan     = 3'd1;
  localparam logic [2:0] StShiftIns = 3'd2;
  localparam logic [2:0] StPut      = 3'd3;
  localparam logic [2:0] StShiftRem = 3'd4;
  localparam logic [2:0] StDone     = 3'd5;

  localparam int unsigned AW = sit_pkg::AddrW;
  localparam int unsigned CW = sit_pkg::CntW;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         occ_q, occ_d;
  logic [AW-1:0]         chk_q, chk_d;
  logic [AW-1:0]         src_q, src_d;
  logic [AW-1:0]         pos_q, pos_d;
  sit_pkg::req_t         req_q, req_d;
  sit_pkg::res_t         res_q, res_d;

  sit_pkg::entry_t       new_ent;
  logic [CW-1:0]         occ_m1;
  logic                  last;
  logic                  q_match;
  logic                  r_match;
  logic [32:0]           ent_end;

  assign new_ent.start   = req_q.time_value;
  assign new_ent.length  = req_q.length_ticks;
  assign new_ent.payload = req_q.payload;
  assign occ_m1          = occ_q - CW'(1);
  assign last            = ({1'b0, chk_q} + CW'(1)) == occ_q;
  assign ent_end         = {1'b0, ram_rdata_i.start} + {1'b0, ram_rdata_i.length};
  assign q_match         = (ram_rdata_i.start <= req_q.time_value) &&
                           ({1'b0, req_q.time_value} < ent_end);
  assign r_match         = (ram_rdata_i.start == req_q.time_value) &&
                           (ram_rdata_i.length == req_q.length_ticks) &&
                           (ram_rdata_i.payload == req_q.payload);

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    chk_d       = chk_q;
    src_d       = src_q;
    pos_d       = pos_q;
    req_d       = req_q;
    res_d       = res_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_o       = '0;

    case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d = req_i;
          res_d = '0;
          case (req_i.op)
            sit_pkg::OpInsert: begin
              if (occ_q == CW'(sit_pkg::Capacity)) begin
                res_d.table_full = 1'b1;
                state_d          = StDone;
              end else if (occ_q == '0) begin
                ram_o.we            = 1'b1;
                ram_o.waddr         = '0;
                ram_o.wdata.start   = req_i.time_value;
                ram_o.wdata.length  = req_i.length_ticks;
                ram_o.wdata.payload = req_i.payload;
                occ_d               = CW'(1);
                res_d.hit           = 1'b1;
                state_d             = StDone;
              end else begin
                ram_o.raddr = '0;
                chk_d       = '0;
                state_d     = StScan;
              end
            end
            sit_pkg::OpQuery, sit_pkg::OpRemove: begin
              if (occ_q == '0) begin
                state_d = StDone;
              end else begin
                ram_o.raddr = '0;
                chk_d       = '0;
                state_d     = StScan;
              end
            end
            default: begin
              state_d = StDone;
            end
          endcase
        end
      end

      StScan: begin
        ram_o.raddr = chk_q + AW'(1);
        chk_d       = chk_q + AW'(1);
        case (req_q.op)
          sit_pkg::OpInsert: begin
            if (ram_rdata_i.start >= req_q.time_value) begin
              pos_d       = chk_q;
              ram_o.raddr = occ_m1[AW-1:0];
              src_d       = occ_m1[AW-1:0];
              state_d     = StShiftIns;
            end else if (last) begin
              ram_o.we    = 1'b1;
              ram_o.waddr = occ_q[AW-1:0];
              ram_o.wdata = new_ent;
              occ_d       = occ_q + CW'(1);
              res_d.hit   = 1'b1;
              state_d     = StDone;
            end
          end
          sit_pkg::OpQuery: begin
            if (q_match) begin
              res_d.hit           = 1'b1;
              res_d.found_start   = ram_rdata_i.start;
              res_d.found_length  = ram_rdata_i.length;
              res_d.found_payload = ram_rdata_i.payload;
              state_d             = StDone;
            end else if (last) begin
              state_d = StDone;
            end
          end
          default: begin
            if (r_match) begin
              if (last) begin
                occ_d     = occ_m1;
                res_d.hit = 1'b1;
                state_d   = StDone;
              end else begin
                src_d   = chk_q + AW'(1);
                state_d = StShiftRem;
              end
            end else if (last) begin
              state_d = StDone;
            end
          end
        endcase
      end

      StShiftIns: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = src_q + AW'(1);
        ram_o.wdata = ram_rdata_i;
        if (src_q == pos_q) begin
          state_d = StPut;
        end else begin
          ram_o.raddr = src_q - AW'(1);
          src_d       = src_q - AW'(1);
        end
      end

      StPut: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = pos_q;
        ram_o.wdata = new_ent;
        occ_d       = occ_q + CW'(1);
        res_d.hit   = 1'b1;
        state_d     = StDone;
      end

      StShiftRem: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = src_q - AW'(1);
        ram_o.wdata = ram_rdata_i;
        if (({1'b0, src_q} + CW'(1)) == occ_q) begin
          occ_d     = occ_m1;
          res_d.hit = 1'b1;
          state_d   = StDone;
        end else begin
          ram_o.raddr = src_q + AW'(1);
          src_d       = src_q + AW'(1);
        end
      end

      StDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    res_o             = res_q;
    res_o.entry_count = occ_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q <= chk_d;
    src_q <= src_d;
    pos_q <= pos_d;
    req_q <= req_d;
    res_q <= res_d;
  end

endmodule
`default_nettype wire

// File: hdl/sorted_interval_table_core.sv
// Top level of the sorted interval table: sequencer, entry memory, result register.
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    op, time_value, length_ticks, payload
//  out_o    out  valid/ready    hit, table_full, found_start, found_length,
//                               found_payload, entry_count
//
// Query, insert and remove scan the stored entries in order; insert and remove then shift
// entries to open or close a slot, with one memory read and one memory write per cycle
// while shifting. A full-table insert or an unused op code goes straight to the result.
// Reset clears the entry count and the control state; memory contents are not cleared.
// A finished result waits in the output register while the next transfer is taken.
`timescale 1ns / 1ps
`default_nettype none
module sorted_interval_table_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sit_in_if.sink       in_i,
  sit_out_if.source    out_o
);

  sit_pkg::req_t     req;
  sit_pkg::res_t     res;
  sit_pkg::res_t     out_q;
  sit_pkg::ram_req_t ram_req;
  sit_pkg::entry_t   ram_rdata;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_q;

  assign req.op           = in_i.op;
  assign req.time_value   = in_i.time_value;
  assign req.length_ticks = in_i.length_ticks;
  assign req.payload      = in_i.payload;

  assign res_ready = !out_valid_q || out_o.ready;

  sit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  sit_ram #(
    .Width (sit_pkg::EntryW),
    .Depth (sit_pkg::Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = out_q.hit;
  assign out_o.table_full    = out_q.table_full;
  assign out_o.found_start   = out_q.found_start;
  assign out_o.found_length  = out_q.found_length;
  assign out_o.found_payload = out_q.found_payload;
  assign out_o.entry_count   = out_q.entry_count;

endmodule
`default_nettype wire
